// File: sv/scsa_pkg.sv
// size-class slab allocator: shared types, codes and constants
// no dependencies; imported by the channel interfaces and the top level
package scsa_pkg;

  // pool geometry
  localparam int unsigned CHUNK_SLOTS = 16;
  localparam int unsigned SlotW = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(CHUNK_SLOTS + 1);

  // payload field widths
  localparam int unsigned ModeW  = 1;
  localparam int unsigned SizeW  = 8;
  localparam int unsigned SlotFW = 4;
  localparam int unsigned BlockW = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ClsW   = 2;
  localparam int unsigned MaskW  = 8;

  // class limits in bytes
  localparam logic [SizeW-1:0] SIZE_CLS8  = 8'd8;
  localparam logic [SizeW-1:0] SIZE_CLS16 = 8'd16;
  localparam logic [SizeW-1:0] SIZE_CLS32 = 8'd32;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_EXHAUSTED = 2'd2,
    STAT_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic [ClsW-1:0] {
    CLS_8  = 2'd0,
    CLS_16 = 2'd1,
    CLS_32 = 2'd2
  } size_class_e;

  // all blocks of a class free
  function automatic logic [MaskW-1:0] full_mask(input logic [ClsW-1:0] cls);
    logic [MaskW-1:0] m;
    case (cls)
      CLS_8:   m = 8'hFF;
      CLS_16:  m = 8'h0F;
      default: m = 8'h03;
    endcase
    return m;
  endfunction

  // index of lowest set bit, zero when none
  function automatic logic [BlockW-1:0] lowest_one(input logic [MaskW-1:0] bits);
    logic [BlockW-1:0] idx;
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = BlockW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: sv/scsa_req_if.sv
// request channel of the slab allocator: valid/ready plus request fields
// depends on scsa_pkg
interface scsa_req_if
  import scsa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ModeW-1:0]    mode;
  logic [SizeW-1:0]    size;
  logic [SlotFW-1:0]   slot;
  logic [BlockW-1:0]   block;

  modport source (output valid, mode, size, slot, block, input ready);
  modport sink   (input valid, mode, size, slot, block, output ready);
endinterface

// File: sv/scsa_rsp_if.sv
// response channel of the slab allocator: valid/ready plus result fields
// depends on scsa_pkg
interface scsa_rsp_if
  import scsa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [StatW-1:0]    status;
  logic [ClsW-1:0]     size_class;
  logic [SlotFW-1:0]   granted_slot;
  logic [BlockW-1:0]   granted_block;

  modport source (output valid, status, size_class, granted_slot, granted_block,
                  input ready);
  modport sink   (input valid, status, size_class, granted_slot, granted_block,
                  output ready);
endinterface

// File: sv/size_class_slab_allocator_unit.sv
// Size-class slab allocator. One request transaction at a time: an allocate
// walks the chunk slots newest first, one slot per cycle through a single
// compare/update unit, and the result is registered at the end of the last
// scan step; an oversized allocate skips the scan and a free goes through the
// execute state. The request side is ready only in the idle state, which is
// re-entered right after the result transaction completes, so a new request
// is taken only once the previous result has been accepted.
// Depends on scsa_pkg, scsa_req_if and scsa_rsp_if.
module size_class_slab_allocator_unit
  import scsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  scsa_req_if.sink    req_i,
  scsa_rsp_if.source  rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FREE = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // pool state
  logic [CHUNK_SLOTS-1:0] in_use_q;
  logic [ClsW-1:0]        cls_mem_q  [CHUNK_SLOTS];
  logic [MaskW-1:0]       mask_mem_q [CHUNK_SLOTS];
  logic [CntW-1:0]        claimed_q;

  // latched request
  logic [ClsW-1:0]   cls_q;
  logic [SlotW-1:0]  idx_q;
  logic              slot_ok_q;
  logic [BlockW-1:0] block_q;

  // result register
  logic [StatW-1:0]  res_stat_q;
  logic [ClsW-1:0]   res_cls_q;
  logic [SlotFW-1:0] res_slot_q;
  logic [BlockW-1:0] res_block_q;

  logic req_fire, rsp_fire;
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = (state_q == ST_DONE);
  assign rsp_o.status        = res_stat_q;
  assign rsp_o.size_class    = res_cls_q;
  assign rsp_o.granted_slot  = res_slot_q;
  assign rsp_o.granted_block = res_block_q;

  // size to class decode
  logic            too_large;
  logic [ClsW-1:0] req_cls;
  always_comb begin
    too_large = 1'b0;
    if (req_i.size <= SIZE_CLS8) begin
      req_cls = CLS_8;
    end else if (req_i.size <= SIZE_CLS16) begin
      req_cls = CLS_16;
    end else if (req_i.size <= SIZE_CLS32) begin
      req_cls = CLS_32;
    end else begin
      req_cls   = CLS_8;
      too_large = 1'b1;
    end
  end

  // shared compare unit: one slot entry per cycle
  logic [MaskW-1:0]  cur_mask;
  logic [ClsW-1:0]   cur_cls;
  logic              cur_used;
  logic              scan_hit;
  logic              scan_last;
  logic              pool_full;
  logic [BlockW-1:0] hit_block;
  logic [MaskW-1:0]  blk_bit;
  logic              block_ok;
  assign cur_mask  = mask_mem_q[idx_q];
  assign cur_cls   = cls_mem_q[idx_q];
  assign cur_used  = in_use_q[idx_q];
  assign scan_hit  = cur_used && (cur_cls == cls_q) && (cur_mask != '0);
  assign scan_last = (idx_q == '0);
  assign pool_full = (32'(claimed_q) >= CHUNK_SLOTS);
  assign hit_block = lowest_one(cur_mask);
  assign blk_bit   = MaskW'(1) << block_q;
  assign block_ok  = (full_mask(cur_cls) & blk_bit) != '0;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (mode_e'(req_i.mode) == MODE_FREE) begin
            state_d = ST_FREE;
          end else if (too_large) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_FREE: state_d = ST_DONE;
      ST_DONE: begin
        if (rsp_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_use_q  <= '0;
      claimed_q <= '0;
    end else begin
      state_q <= state_d;
      // claim the next unused slot when the scan finds nothing and the pool is not full
      if (state_q == ST_SCAN && !scan_hit && scan_last && !pool_full) begin
        in_use_q[SlotW'(claimed_q)] <= 1'b1;
        claimed_q                   <= claimed_q + CntW'(1);
      end
    end
  end

  // request latch, slot tables and result register
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          cls_q   <= req_cls;
          block_q <= req_i.block;
          if (mode_e'(req_i.mode) == MODE_FREE) begin
            slot_ok_q <= (32'(req_i.slot) < CHUNK_SLOTS);
            idx_q     <= SlotW'(req_i.slot);
          end else begin
            slot_ok_q <= 1'b1;
            idx_q     <= SlotW'(CHUNK_SLOTS - 1);
          end
          // oversized allocate answers right away
          res_stat_q  <= STAT_TOO_LARGE;
          res_cls_q   <= CLS_8;
          res_slot_q  <= '0;
          res_block_q <= '0;
        end
      end
      ST_SCAN: begin
        res_cls_q <= cls_q;
        if (scan_hit) begin
          mask_mem_q[idx_q] <= cur_mask & (cur_mask - MaskW'(1));
          res_stat_q  <= STAT_OK;
          res_slot_q  <= SlotFW'(idx_q);
          res_block_q <= hit_block;
        end else if (scan_last) begin
          res_block_q <= '0;
          if (pool_full) begin
            res_stat_q <= STAT_EXHAUSTED;
            res_slot_q <= '0;
          end else begin
            cls_mem_q[SlotW'(claimed_q)]  <= cls_q;
            mask_mem_q[SlotW'(claimed_q)] <= full_mask(cls_q) & ~MaskW'(1);
            res_stat_q <= STAT_OK;
            res_slot_q <= SlotFW'(claimed_q);
          end
        end else begin
          idx_q <= idx_q - SlotW'(1);
        end
      end
      ST_FREE: begin
        res_slot_q  <= '0;
        res_block_q <= '0;
        if (!slot_ok_q || !cur_used) begin
          res_stat_q <= STAT_BAD_FREE;
          res_cls_q  <= CLS_8;
        end else if (!block_ok) begin
          res_stat_q <= STAT_BAD_FREE;
          res_cls_q  <= cur_cls;
        end else begin
          mask_mem_q[idx_q] <= cur_mask | blk_bit;
          res_stat_q <= STAT_OK;
          res_cls_q  <= cur_cls;
        end
      end
      default: ;
    endcase
  end

endmodule
